@@ sv/ffba_pkg.sv @@
// Shared types and constants for the first-fit block allocator.
// Used by the channel interfaces, the shared ALU and the top level.
package ffba_pkg;

  // Defaults for the top-level parameters.
  localparam int POOL_BLOCKS_DEF  = 256;
  localparam int BLOCK_BYTES_DEF  = 16;
  localparam int HEADER_BYTES_DEF = 8;

  // Fixed field widths of the words on the two channels.
  localparam int REQ_W    = 12;
  localparam int REL_W    = 8;
  localparam int START_W  = 8;
  localparam int BLOCKS_W = 9;
  localparam int REQ_MAX  = (1 << REQ_W) - 1;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    STAT_ALLOC = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_FREED = 2'd2
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

@@ sv/ffba_if.sv @@
// Valid/ready channel interfaces for request words and result words.
// Depends on ffba_pkg for the field types and widths.
interface ffba_in_if;
  import ffba_pkg::*;

  logic              valid;
  logic              ready;
  mode_t             mode;
  logic [REQ_W-1:0]  request_bytes;
  logic [REL_W-1:0]  release_block;

  modport source (output valid, mode, request_bytes, release_block, input ready);
  modport sink   (input valid, mode, request_bytes, release_block, output ready);
endinterface

interface ffba_out_if;
  import ffba_pkg::*;

  logic                valid;
  logic                ready;
  status_t             status;
  logic [START_W-1:0]  region_start;
  logic [BLOCKS_W-1:0] region_blocks;

  modport source (output valid, status, region_start, region_blocks, input ready);
  modport sink   (input valid, status, region_start, region_blocks, output ready);
endinterface

@@ sv/first_fit_block_allocator.sv @@
// First-fit block allocator: a pool of POOL_BLOCKS blocks is kept as an address-ordered
// list of free runs in two RAMs (run length, link to next run). After reset the block
// runs a clearing pass over both RAMs and takes no word meanwhile. It works on one
// request at a time; in_ch.ready is high only when it is idle, and a finished result
// waits in an output register while the next request is taken. An allocate turns the
// byte count into blocks by one multiply with the rounded-up reciprocal of the block
// size, then walks the list: each run visited costs one RAM read and one compare, a
// split writes the remainder as a new run, and a run is skipped when its remainder
// would leave the pool. A free walks the runs below the freed block and merges with
// the runs on either side where they adjoin. A result that finds the output register
// still full waits until that word is taken. Both loops are set by the registered RAM
// read and the single shared adder.
module first_fit_block_allocator #(
  parameter int POOL_BLOCKS  = ffba_pkg::POOL_BLOCKS_DEF,
  parameter int BLOCK_BYTES  = ffba_pkg::BLOCK_BYTES_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ffba_in_if.sink   in_ch,
  ffba_out_if.source out_ch
);
  import ffba_pkg::*;

  localparam int W   = $clog2(POOL_BLOCKS + 1);
  localparam int AWR = $clog2(POOL_BLOCKS);
  localparam int TW  = $clog2(REQ_MAX + HEADER_BYTES + BLOCK_BYTES);
  localparam int DW  = (W + 1 > TW) ? W + 1 : TW;
  localparam int RSH = TW + $clog2(BLOCK_BYTES);
  localparam int MW  = TW + 2;
  localparam int PW  = TW + MW;
  localparam logic [MW-1:0] RECIP = MW'((2 ** RSH + BLOCK_BYTES - 1) / BLOCK_BYTES);
  localparam logic [W-1:0] NULL_L = W'(POOL_BLOCKS);

  typedef enum logic [17:0] {
    S_CLR   = 18'h00001,
    S_IDLE  = 18'h00002,
    S_DIV   = 18'h00004,
    S_NCHK  = 18'h00008,
    S_AWALK = 18'h00010,
    S_ACMP  = 18'h00020,
    S_ASPL  = 18'h00040,
    S_AW1   = 18'h00080,
    S_AW2   = 18'h00100,
    S_FWALK = 18'h00200,
    S_FADV  = 18'h00400,
    S_FRD1  = 18'h00800,
    S_FRD2  = 18'h01000,
    S_FRD3  = 18'h02000,
    S_FRM   = 18'h04000,
    S_FLCHK = 18'h08000,
    S_FLM   = 18'h10000,
    S_DONE  = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  logic [AWR-1:0] clr_idx_r, clr_idx_nxt;
  logic [W-1:0]   head_r, head_nxt;
  logic [TW-1:0]  tot_r, tot_nxt;
  logic [W-1:0]   cur_r, cur_nxt;
  logic [W-1:0]   prev_r, prev_nxt;
  logic [W-1:0]   steps_r, steps_nxt;
  logic [W-1:0]   now_r, now_nxt;
  logic [W-1:0]   lnk_r, lnk_nxt;
  logic [W-1:0]   diff_r, diff_nxt;
  logic [W-1:0]   rest_r, rest_nxt;
  logic [W-1:0]   lnow_r, lnow_nxt;
  logic [W-1:0]   lnext_r, lnext_nxt;
  logic [W-1:0]   lprev_r, lprev_nxt;
  logic [W-1:0]   newlen_r, newlen_nxt;
  logic [W-1:0]   newlnk_r, newlnk_nxt;
  logic           mright_r, mright_nxt;
  status_t        pend_status_r, pend_status_nxt;
  logic [W-1:0]   pend_start_r, pend_start_nxt;
  logic [W-1:0]   pend_blocks_r, pend_blocks_nxt;
  logic           out_valid_r, out_valid_nxt;
  status_t        out_status_r, out_status_nxt;
  logic [START_W-1:0]  out_start_r, out_start_nxt;
  logic [BLOCKS_W-1:0] out_blocks_r, out_blocks_nxt;

  // RAM ports.
  logic           len_we, lnk_we;
  logic [AWR-1:0] len_waddr, lnk_waddr, len_raddr, lnk_raddr;
  logic [W-1:0]   len_wdata, lnk_wdata, len_rd, lnk_rd;

  // Shared ALU ports.
  alu_op_t        alu_op;
  logic [DW-1:0]  alu_a, alu_b, alu_res;
  logic           alu_cout;

  logic [PW-1:0]  quot_prod;
  logic [W-1:0]   sat_val;
  logic           in_oob;

  ffba_ram #(.WIDTH(W), .DEPTH(POOL_BLOCKS)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .raddr (len_raddr),
    .rdata (len_rd)
  );

  ffba_ram #(.WIDTH(W), .DEPTH(POOL_BLOCKS)) u_lnk_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (lnk_raddr),
    .rdata (lnk_rd)
  );

  ffba_alu #(.DW(DW)) u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .res  (alu_res),
    .cout (alu_cout)
  );

  // Block count by reciprocal multiply, and saturation of merged lengths.
  assign quot_prod = PW'(tot_r) * PW'(RECIP);
  assign sat_val = (alu_res > DW'(POOL_BLOCKS)) ? NULL_L : W'(alu_res);
  assign in_oob  = (32'(in_ch.release_block) >= 32'(POOL_BLOCKS));

  // Sequencer.
  always_comb begin
    state_nxt       = state_r;
    clr_idx_nxt     = clr_idx_r;
    head_nxt        = head_r;
    tot_nxt         = tot_r;
    cur_nxt         = cur_r;
    prev_nxt        = prev_r;
    steps_nxt       = steps_r;
    now_nxt         = now_r;
    lnk_nxt         = lnk_r;
    diff_nxt        = diff_r;
    rest_nxt        = rest_r;
    lnow_nxt        = lnow_r;
    lnext_nxt       = lnext_r;
    lprev_nxt       = lprev_r;
    newlen_nxt      = newlen_r;
    newlnk_nxt      = newlnk_r;
    mright_nxt      = mright_r;
    pend_status_nxt = pend_status_r;
    pend_start_nxt  = pend_start_r;
    pend_blocks_nxt = pend_blocks_r;
    out_status_nxt  = out_status_r;
    out_start_nxt   = out_start_r;
    out_blocks_nxt  = out_blocks_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;

    len_we    = 1'b0;
    lnk_we    = 1'b0;
    len_waddr = AWR'(cur_r);
    lnk_waddr = AWR'(cur_r);
    len_wdata = '0;
    lnk_wdata = NULL_L;
    len_raddr = AWR'(cur_r);
    lnk_raddr = AWR'(cur_r);
    alu_op    = ALU_ADD;
    alu_a     = '0;
    alu_b     = '0;

    unique case (state_r)
      // Reset image: run 0 covers the pool, every link is null.
      S_CLR: begin
        len_we      = 1'b1;
        lnk_we      = 1'b1;
        len_waddr   = clr_idx_r;
        lnk_waddr   = clr_idx_r;
        len_wdata   = (clr_idx_r == '0) ? NULL_L : '0;
        lnk_wdata   = NULL_L;
        clr_idx_nxt = clr_idx_r + AWR'(1);
        if (clr_idx_r == AWR'(POOL_BLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.mode == MODE_ALLOC) begin
            tot_nxt     = TW'(in_ch.request_bytes) + TW'(HEADER_BYTES + BLOCK_BYTES - 1);
            state_nxt   = S_DIV;
          end else if (in_oob) begin
            pend_status_nxt = STAT_FREED;
            pend_start_nxt  = '0;
            pend_blocks_nxt = '0;
            state_nxt       = S_DONE;
          end else begin
            now_nxt   = W'(in_ch.release_block);
            prev_nxt  = NULL_L;
            cur_nxt   = head_r;
            steps_nxt = '0;
            state_nxt = S_FWALK;
          end
        end
      end

      // Division by the block size through its rounded-up reciprocal.
      S_DIV: begin
        tot_nxt   = TW'(quot_prod >> RSH);
        state_nxt = S_NCHK;
      end

      // A request larger than the pool can never fit.
      S_NCHK: begin
        alu_op = ALU_SUB;
        alu_a  = DW'(POOL_BLOCKS);
        alu_b  = DW'(tot_r);
        if (!alu_cout) begin
          pend_status_nxt = STAT_NOFIT;
          pend_start_nxt  = '0;
          pend_blocks_nxt = '0;
          state_nxt       = S_DONE;
        end else begin
          prev_nxt  = NULL_L;
          cur_nxt   = head_r;
          steps_nxt = '0;
          state_nxt = S_AWALK;
        end
      end

      // Visit the next run: read its length and link.
      S_AWALK: begin
        if (cur_r >= NULL_L || steps_r == NULL_L) begin
          pend_status_nxt = STAT_NOFIT;
          pend_start_nxt  = '0;
          pend_blocks_nxt = '0;
          state_nxt       = S_DONE;
        end else begin
          state_nxt = S_ACMP;
        end
      end

      // Compare the run length against the need.
      S_ACMP: begin
        alu_op  = ALU_SUB;
        alu_a   = DW'(len_rd);
        alu_b   = DW'(tot_r);
        lnk_nxt = lnk_rd;
        if (alu_res == '0) begin
          // Exact fit: unlink the run.
          if (prev_r >= NULL_L) begin
            head_nxt = lnk_rd;
          end else begin
            lnk_we    = 1'b1;
            lnk_waddr = AWR'(prev_r);
            lnk_wdata = lnk_rd;
          end
          pend_status_nxt = STAT_ALLOC;
          pend_start_nxt  = cur_r;
          pend_blocks_nxt = W'(tot_r);
          state_nxt       = S_DONE;
        end else if (alu_cout) begin
          diff_nxt  = W'(alu_res);
          state_nxt = S_ASPL;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = lnk_rd;
          steps_nxt = steps_r + W'(1);
          state_nxt = S_AWALK;
        end
      end

      // Start of the remainder; a remainder outside the pool skips the run.
      S_ASPL: begin
        alu_op = ALU_ADD;
        alu_a  = DW'(cur_r);
        alu_b  = DW'(tot_r);
        if (alu_res < DW'(POOL_BLOCKS)) begin
          rest_nxt  = W'(alu_res);
          state_nxt = S_AW1;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = lnk_r;
          steps_nxt = steps_r + W'(1);
          state_nxt = S_AWALK;
        end
      end

      // Remainder becomes a free run carrying the old link.
      S_AW1: begin
        len_we    = 1'b1;
        len_waddr = AWR'(rest_r);
        len_wdata = diff_r;
        lnk_we    = 1'b1;
        lnk_waddr = AWR'(rest_r);
        lnk_wdata = lnk_r;
        state_nxt = S_AW2;
      end

      // Granted length stays at the start; the predecessor points at the remainder.
      S_AW2: begin
        len_we    = 1'b1;
        len_waddr = AWR'(cur_r);
        len_wdata = W'(tot_r);
        if (prev_r >= NULL_L) begin
          head_nxt = rest_r;
        end else begin
          lnk_we    = 1'b1;
          lnk_waddr = AWR'(prev_r);
          lnk_wdata = rest_r;
        end
        pend_status_nxt = STAT_ALLOC;
        pend_start_nxt  = cur_r;
        pend_blocks_nxt = W'(tot_r);
        state_nxt       = S_DONE;
      end

      // Walk to the first run at or above the freed block.
      S_FWALK: begin
        alu_op = ALU_SUB;
        alu_a  = DW'(cur_r);
        alu_b  = DW'(now_r);
        if (steps_r == NULL_L) begin
          cur_nxt   = NULL_L;
          state_nxt = S_FRD1;
        end else if (cur_r >= NULL_L || alu_cout) begin
          state_nxt = S_FRD1;
        end else begin
          state_nxt = S_FADV;
        end
      end

      S_FADV: begin
        prev_nxt  = cur_r;
        cur_nxt   = lnk_rd;
        steps_nxt = steps_r + W'(1);
        state_nxt = S_FWALK;
      end

      // Read the freed length and the successor's link.
      S_FRD1: begin
        len_raddr = AWR'(now_r);
        state_nxt = S_FRD2;
      end

      // Read the successor's length.
      S_FRD2: begin
        lnow_nxt  = len_rd;
        lnk_nxt   = lnk_rd;
        state_nxt = S_FRD3;
      end

      // Read the predecessor's length; check whether the successor adjoins.
      S_FRD3: begin
        lnext_nxt  = len_rd;
        len_raddr  = AWR'(prev_r);
        alu_op     = ALU_ADD;
        alu_a      = DW'(now_r);
        alu_b      = DW'(lnow_r);
        mright_nxt = (cur_r < NULL_L) && (alu_res == DW'(cur_r));
        state_nxt  = S_FRM;
      end

      // Merge with the successor, or link to it.
      S_FRM: begin
        lprev_nxt = len_rd;
        lnk_we    = 1'b1;
        lnk_waddr = AWR'(now_r);
        alu_op    = ALU_ADD;
        alu_a     = DW'(lnow_r);
        alu_b     = DW'(lnext_r);
        if (mright_r) begin
          len_we     = 1'b1;
          len_waddr  = AWR'(now_r);
          len_wdata  = sat_val;
          lnk_wdata  = lnk_r;
          newlen_nxt = sat_val;
          newlnk_nxt = lnk_r;
        end else begin
          lnk_wdata  = cur_r;
          newlen_nxt = lnow_r;
          newlnk_nxt = cur_r;
        end
        state_nxt = S_FLCHK;
      end

      // Check whether the predecessor adjoins; if not, link it (or the head) here.
      S_FLCHK: begin
        alu_op = ALU_ADD;
        alu_a  = DW'(prev_r);
        alu_b  = DW'(lprev_r);
        if (prev_r < NULL_L && alu_res == DW'(now_r)) begin
          state_nxt = S_FLM;
        end else begin
          if (prev_r >= NULL_L) begin
            head_nxt = now_r;
          end else begin
            lnk_we    = 1'b1;
            lnk_waddr = AWR'(prev_r);
            lnk_wdata = now_r;
          end
          pend_status_nxt = STAT_FREED;
          pend_start_nxt  = now_r;
          pend_blocks_nxt = newlen_r;
          state_nxt       = S_DONE;
        end
      end

      // Fold the freed run into its predecessor.
      S_FLM: begin
        alu_op          = ALU_ADD;
        alu_a           = DW'(lprev_r);
        alu_b           = DW'(newlen_r);
        len_we          = 1'b1;
        len_waddr       = AWR'(prev_r);
        len_wdata       = sat_val;
        lnk_we          = 1'b1;
        lnk_waddr       = AWR'(prev_r);
        lnk_wdata       = newlnk_r;
        pend_status_nxt = STAT_FREED;
        pend_start_nxt  = prev_r;
        pend_blocks_nxt = sat_val;
        state_nxt       = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_start_nxt  = START_W'(pend_start_r);
          out_blocks_nxt = BLOCKS_W'(pend_blocks_r);
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      head_r      <= '0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      head_r      <= head_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    tot_r         <= tot_nxt;
    cur_r         <= cur_nxt;
    prev_r        <= prev_nxt;
    now_r         <= now_nxt;
    lnk_r         <= lnk_nxt;
    diff_r        <= diff_nxt;
    rest_r        <= rest_nxt;
    lnow_r        <= lnow_nxt;
    lnext_r       <= lnext_nxt;
    lprev_r       <= lprev_nxt;
    newlen_r      <= newlen_nxt;
    newlnk_r      <= newlnk_nxt;
    mright_r      <= mright_nxt;
    pend_status_r <= pend_status_nxt;
    pend_start_r  <= pend_start_nxt;
    pend_blocks_r <= pend_blocks_nxt;
    out_status_r  <= out_status_nxt;
    out_start_r   <= out_start_nxt;
    out_blocks_r  <= out_blocks_nxt;
  end

  // Channel outputs.
  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.region_start  = out_start_r;
  assign out_ch.region_blocks = out_blocks_r;

  // One request at a time: the input is closed in the cycle after a word is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while a request is in progress");

  // The list head is always a pool block or the null link.
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= NULL_L)
    else $error("free list head outside the pool");

  // A walk never visits more runs than the pool holds.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= NULL_L)
    else $error("free list walk ran past its bound");

  // A finished result waits while the output register is still full.
  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ch.ready) |=> (state_r == S_DONE))
    else $error("result overwrote an untaken output word");

endmodule

@@ sv/ffba_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffba_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/ffba_alu.sv @@
// Shared add/subtract unit used by the sequencer's length, address and compare steps.
// Depends on ffba_pkg for the operation code.
module ffba_alu #(
  parameter int DW = 10
) (
  input  ffba_pkg::alu_op_t op,
  input  logic [DW-1:0]     a,
  input  logic [DW-1:0]     b,
  output logic [DW-1:0]     res,
  output logic              cout
);
  import ffba_pkg::*;

  logic [DW:0] sum;

  // On a subtract, cout is set when a >= b (no borrow).
  always_comb begin
    unique case (op)
      ALU_ADD: sum = {1'b0, a} + {1'b0, b};
      ALU_SUB: sum = {1'b0, a} + {1'b0, ~b} + (DW + 1)'(1);
      default: sum = '0;
    endcase
  end

  assign res  = sum[DW-1:0];
  assign cout = sum[DW];

endmodule

@@ sim/first_fit_block_allocator_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the first-fit block allocator.
// Depends on ffba_pkg, the ffba channel interfaces and the RTL top level.
module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  localparam int POOL = POOL_BLOCKS_DEF;
  localparam int BLK  = BLOCK_BYTES_DEF;
  localparam int HDR  = HEADER_BYTES_DEF;

  // Two copies of the free list: one used while planning stimulus, one that
  // follows the words the block actually accepts.
  localparam int PLAN = 0;
  localparam int LIVE = 1;

  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;

  // Receiver stall styles.
  localparam int RX_OPEN   = 0;
  localparam int RX_HALF   = 1;
  localparam int RX_SPARSE = 2;

  typedef struct packed {
    mode_t              mode;
    logic [REQ_W-1:0]   bytes;
    logic [REL_W-1:0]   blk;
  } pool_req_t;

  typedef struct packed {
    status_t             status;
    logic [START_W-1:0]  start;
    logic [BLOCKS_W-1:0] blocks;
  } pool_reply_t;

  logic clk;
  logic rst_n;

  ffba_in_if  in_if ();
  ffba_out_if out_if ();

  first_fit_block_allocator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  // Free-list state of the predictor.
  logic [8:0] run_len  [0:1][0:POOL-1];
  logic [8:0] run_nxt  [0:1][0:POOL-1];
  logic [8:0] list_head [0:1];

  pool_req_t   req_q[$];
  pool_reply_t reply_q[$];
  int          held_q[$];

  int burst_left = 0;
  int gap_left   = 0;
  int hold_left  = 0;
  int rx_span    = 0;
  int rx_style   = RX_OPEN;
  int quiet      = 0;
  int fails      = 0;
  int last_freed = -1;
  bit in_taken   = 1'b0;
  bit hold_long  = 1'b0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void pool_clear(input int c);
    int i;
    for (i = 0; i < POOL; i++) begin
      run_len[c][i] = '0;
      run_nxt[c][i] = 9'(POOL);
    end
    run_len[c][0] = 9'(POOL);
    list_head[c] = '0;
  endfunction

  function automatic int sat_len(input int s);
    return (s > POOL) ? POOL : s;
  endfunction

  // Point the link that leads to a run at target; the head when prev is null.
  function automatic void relink(input int c, input int prev, input int target);
    if (prev >= POOL) begin
      list_head[c] = 9'(target);
    end else begin
      run_nxt[c][prev] = 9'(target);
    end
  endfunction

  // Apply one request word to a free-list copy and return the reply word.
  function automatic pool_reply_t pool_apply(input int c, input pool_req_t r);
    pool_reply_t g;
    int need, prev, cur, steps, len, now, nxt, first;
    g.start  = '0;
    g.blocks = '0;
    if (r.mode == MODE_ALLOC) begin
      g.status = STAT_NOFIT;
      need = (int'(r.bytes) + HDR + BLK - 1) / BLK;
      if (need > POOL) return g;
      prev = POOL;
      cur  = list_head[c];
      // First-fit walk; a walk that never ends counts as reaching the end.
      for (steps = 0; steps < POOL && cur < POOL; steps++) begin
        len = run_len[c][cur];
        if (len == need || (len > need && cur + need < POOL)) begin
          if (len == need) begin
            relink(c, prev, run_nxt[c][cur]);
          end else begin
            run_len[c][cur + need] = 9'(len - need);
            run_nxt[c][cur + need] = run_nxt[c][cur];
            run_len[c][cur] = 9'(need);
            relink(c, prev, cur + need);
          end
          g.status = STAT_ALLOC;
          g.start  = 8'(cur);
          g.blocks = 9'(need);
          return g;
        end
        prev = cur;
        cur  = run_nxt[c][cur];
      end
      return g;
    end
    g.status = STAT_FREED;
    now = r.blk;
    if (now >= POOL) return g;
    prev = POOL;
    nxt  = list_head[c];
    for (steps = 0; steps < POOL && nxt < POOL && nxt < now; steps++) begin
      prev = nxt;
      nxt  = run_nxt[c][nxt];
    end
    if (steps >= POOL) nxt = POOL;
    // Merge with the run that follows, then with the one before.
    if (nxt < POOL && now + int'(run_len[c][now]) == nxt) begin
      run_len[c][now] = 9'(sat_len(int'(run_len[c][now]) + int'(run_len[c][nxt])));
      run_nxt[c][now] = run_nxt[c][nxt];
    end else begin
      run_nxt[c][now] = 9'(nxt);
    end
    len   = run_len[c][now];
    first = now;
    if (prev < POOL && prev + int'(run_len[c][prev]) == now) begin
      run_len[c][prev] = 9'(sat_len(int'(run_len[c][prev]) + int'(run_len[c][now])));
      run_nxt[c][prev] = run_nxt[c][now];
      first = prev;
      len   = run_len[c][prev];
    end else begin
      relink(c, prev, now);
    end
    g.start  = 8'(first);
    g.blocks = 9'(len);
    return g;
  endfunction

  function automatic pool_req_t make_alloc(input int bytes);
    pool_req_t r;
    r.mode  = MODE_ALLOC;
    r.bytes = REQ_W'(bytes);
    r.blk   = REL_W'($urandom);
    return r;
  endfunction

  function automatic pool_req_t make_free(input int blk);
    pool_req_t r;
    r.mode  = MODE_FREE;
    r.bytes = REQ_W'($urandom);
    r.blk   = REL_W'(blk);
    return r;
  endfunction

  // Queue a word and track which regions are handed out.
  function automatic void plan_push(input pool_req_t r);
    pool_reply_t g;
    int i;
    g = pool_apply(PLAN, r);
    if (r.mode == MODE_ALLOC) begin
      if (g.status == STAT_ALLOC) held_q.push_back(g.start);
    end else begin
      last_freed = r.blk;
      for (i = 0; i < held_q.size(); i++) begin
        if (held_q[i] == r.blk) begin
          held_q.delete(i);
          break;
        end
      end
    end
    req_q.push_back(r);
  endfunction

  // Mostly small requests, some large ones, and the rounding edges.
  function automatic int rand_bytes();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      case ($urandom_range(0, 4))
        0: return 0;
        1: return 8;
        2: return 9;
        3: return 4088;
        default: return REQ_MAX;
      endcase
    end
    if (sel < 75) return $urandom_range(0, 120);
    if (sel < 93) return $urandom_range(0, 1000);
    return $urandom_range(0, REQ_MAX);
  endfunction

  // Allocate/free traffic; the noisy form adds bogus and repeated frees.
  function automatic void plan_random(input int n, input bit noisy);
    int k, pick, idx;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (noisy && pick < 20) begin
        plan_push(make_free($urandom_range(0, POOL - 1)));
      end else if (noisy && pick < 32 && last_freed >= 0) begin
        plan_push(make_free(last_freed));
      end else if (held_q.size() > 0 &&
                   $urandom_range(0, 99) < ((held_q.size() > 24) ? 70 : 40)) begin
        idx = $urandom_range(0, held_q.size() - 1);
        plan_push(make_free(held_q[idx]));
      end else begin
        plan_push(make_alloc(rand_bytes()));
      end
    end
  endfunction

  task automatic wait_drained();
    while (req_q.size() != 0 || in_if.valid || reply_q.size() != 0) @(posedge clk);
  endtask

  // Request driver: bursts of words with random gaps between them.
  always @(negedge clk) begin : req_driver
    pool_req_t nreq;
    logic      nvalid;
    nvalid     = in_if.valid;
    nreq.mode  = in_if.mode;
    nreq.bytes = in_if.request_bytes;
    nreq.blk   = in_if.release_block;
    if (in_taken) begin
      in_taken = 1'b0;
      nvalid   = 1'b0;
    end
    if (rst_n && !nvalid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (req_q.size() > 0) begin
        nreq   = req_q.pop_front();
        nvalid = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
    in_if.valid         <= nvalid;
    in_if.mode          <= nreq.mode;
    in_if.request_bytes <= nreq.bytes;
    in_if.release_block <= nreq.blk;
  end

  // Result receiver: changing stall styles, plus one long hold-off on request.
  always @(negedge clk) begin : reply_sink
    logic nready;
    if (hold_long) begin
      hold_left = LONG_HOLD;
      hold_long = 1'b0;
    end
    if (rx_span == 0) begin
      rx_style = $urandom_range(RX_OPEN, RX_SPARSE);
      rx_span  = $urandom_range(10, 150);
    end else begin
      rx_span--;
    end
    case (rx_style)
      RX_OPEN: nready = 1'b1;
      RX_HALF: nready = 1'($urandom_range(0, 1));
      default: nready = ($urandom_range(0, 3) == 0);
    endcase
    if (hold_left > 0) begin
      hold_left--;
      nready = 1'b0;
    end
    out_if.ready <= nready;
  end

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk) begin : monitor
    pool_req_t   seen;
    pool_reply_t want;
    bit          moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        seen.mode  = in_if.mode;
        seen.bytes = in_if.request_bytes;
        seen.blk   = in_if.release_block;
        reply_q.push_back(pool_apply(LIVE, seen));
        in_taken = 1'b1;
        moved    = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        if (reply_q.size() == 0) begin
          $error("result word with none expected: status %0d start %0d blocks %0d",
                 out_if.status, out_if.region_start, out_if.region_blocks);
          fails++;
        end else begin
          want = reply_q.pop_front();
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.status);
            fails++;
          end
          if (out_if.region_start !== want.start) begin
            $error("region_start: expected %0d, got %0d", want.start, out_if.region_start);
            fails++;
          end
          if (out_if.region_blocks !== want.blocks) begin
            $error("region_blocks: expected %0d, got %0d", want.blocks, out_if.region_blocks);
            fails++;
          end
        end
      end
      // Watchdog on cycles with no word moving on either channel.
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAIL first_fit_block_allocator");
        $finish;
      end
    end
  end

  // Stimulus plan and end of run.
  initial begin : stimulus
    in_if.valid         = 1'b0;
    in_if.mode          = MODE_ALLOC;
    in_if.request_bytes = '0;
    in_if.release_block = '0;
    out_if.ready        = 1'b0;
    rst_n               = 1'b0;
    pool_clear(PLAN);
    pool_clear(LIVE);

    // Directed: rounding edges, split, exact fit, merges on both sides,
    // a full-pool grant, an empty list and an oversized request.
    plan_push(make_alloc(0));
    plan_push(make_alloc(8));
    plan_push(make_alloc(9));
    plan_push(make_alloc(24));
    plan_push(make_alloc(REQ_MAX));
    plan_push(make_alloc(100));
    plan_push(make_free(2));
    plan_push(make_free(6));
    plan_push(make_free(4));
    plan_push(make_alloc(16));
    plan_push(make_free(0));
    plan_push(make_free(1));
    plan_push(make_alloc(0));
    plan_push(make_free(0));
    plan_push(make_free(2));
    plan_push(make_alloc(4088));
    plan_push(make_alloc(0));
    plan_push(make_free(0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The sender waits here until every expected result has come back.
    wait_drained();

    // Well-formed traffic; the receiver holds off at the start so the block backs up.
    plan_random(410, 1'b0);
    hold_long = 1'b1;
    wait_drained();

    // Corrupting traffic last, since a damaged list stays damaged.
    plan_random(120, 1'b1);
    wait_drained();
    repeat (40) @(posedge clk);

    if (fails == 0 && reply_q.size() == 0) begin
      $display("PASS first_fit_block_allocator");
    end else begin
      $display("FAIL first_fit_block_allocator");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/ffba_pkg.sv
sv/ffba_if.sv
sv/ffba_ram.sv
sv/ffba_alu.sv
sv/first_fit_block_allocator.sv
sim/first_fit_block_allocator_tb.sv
